// ===== rtl/htn_pkg.sv =====
// constants, state types and step functions of the height-to-normal pipeline
package htn_pkg;

    localparam int H_W       = 24;             // input height width
    localparam int HF        = 12;             // fractional bits of a height
    localparam int OUT_BITS  = 16;             // width of an output component
    localparam int NRM_FRAC  = 24;             // fractional bits of unit-vector terms
    localparam int D_W       = H_W + 1;        // neighbour minus centre
    localparam int SUM_W     = NRM_FRAC + 4;   // signed sum of four unit terms
    localparam int SQ_W      = 2 * SUM_W;      // root and remainder width
    localparam int S1_STEPS  = D_W;            // root of a^2 + b^2 + 1
    localparam int S2_STEPS  = SUM_W - 1;      // root of the sum's squared length
    localparam int DIV_STEPS = NRM_FRAC + 1;   // quotient bits, value up to 1.0
    localparam int Q_W       = DIV_STEPS;
    localparam int L2_W      = SUM_W - 1;      // length of the sum vector
    localparam int T_W       = NRM_FRAC + 2;   // mapped component, 0 to 2.0
    localparam int M_W       = T_W + OUT_BITS;
    localparam int N_TRI     = 4;
    localparam int N_LANE    = 3 * N_TRI;
    localparam int LAT       = 11 + S1_STEPS + S2_STEPS + 2 * DIV_STEPS;

    // neighbour order: up, down, left, right
    localparam int DIR_UP    = 0;
    localparam int DIR_DOWN  = 1;
    localparam int DIR_LEFT  = 2;
    localparam int DIR_RIGHT = 3;

    // triangles: up-left, down-left, down-right, up-right
    localparam int TRI_A [N_TRI] = '{DIR_UP, DIR_LEFT, DIR_DOWN, DIR_RIGHT};
    localparam int TRI_B [N_TRI] = '{DIR_LEFT, DIR_DOWN, DIR_RIGHT, DIR_UP};

    // lanes within a triangle
    localparam int LN_A = 0;
    localparam int LN_B = 1;
    localparam int LN_Z = 2;

    typedef struct packed {
        logic [SQ_W-1:0] v;
        logic [SQ_W-1:0] r;
    } t_sq_st;

    typedef struct packed {
        logic [SQ_W-1:0] rem;
        logic [Q_W-1:0]  q;
    } t_dv_st;

    // one digit of the bitwise integer square root
    function automatic t_sq_st sqrt_step(t_sq_st st, logic [SQ_W-1:0] bit_w);
        t_sq_st          nx;
        logic [SQ_W-1:0] trial;
        trial = st.r + bit_w;
        if (st.v >= trial) begin
            nx.v = st.v - trial;
            nx.r = (st.r >> 1) + bit_w;
        end else begin
            nx.v = st.v;
            nx.r = st.r >> 1;
        end
        return nx;
    endfunction

    // one quotient bit of restoring division, divisor already shifted
    function automatic t_dv_st div_step(t_dv_st st, logic [SQ_W-1:0] dsh);
        t_dv_st nx;
        logic   ge;
        ge     = (st.rem >= dsh);
        nx.rem = ge ? (st.rem - dsh) : st.rem;
        nx.q   = {st.q[Q_W-2:0], ge};
        return nx;
    endfunction

    function automatic logic [D_W-1:0] mag_d(logic signed [D_W-1:0] x);
        return x[D_W-1] ? D_W'(-x) : D_W'(x);
    endfunction

    function automatic logic [SUM_W-1:0] mag_s(logic signed [SUM_W-1:0] x);
        return x[SUM_W-1] ? SUM_W'(-x) : SUM_W'(x);
    endfunction

    // signed unit term, zero when its triangle is absent
    function automatic logic signed [SUM_W-1:0] sterm(logic [Q_W-1:0] q, logic neg,
                                                     logic present);
        logic signed [SUM_W-1:0] v;
        v = SUM_W'(q);
        if (!present) begin
            return '0;
        end
        return neg ? -v : v;
    endfunction

endpackage

// ===== rtl/height_to_normal_pixel.sv =====
// surface normal of one height-map pixel, fully pipelined
//
// Input channel (i_valid / o_ready): a pixel's height, its four neighbours'
// heights (signed, HF fractional bits) and four flags telling which neighbours
// exist. Output channel (o_valid / i_ready): the normal's x, y and z mapped to
// unsigned fractions where all ones is 1.0, and a clamp flag.
// Each pixel is independent. One transfer is taken every cycle while the
// receiver does not stall. The pipeline has three entry stages, a 25-step
// square root and a 25-step divider per triangle, a 27-step root and 25-step
// divider for the normalisation, then mapping, scaling and the output register.
// Every root and divider step is one register stage holding one result bit.
// A pixel with no usable triangle gives the upward normal (0,0,1).
// Reset empties the pipeline; payload is not cleared.
// When the receiver stalls the whole pipeline holds; o_ready is low only
// while the output register is full and not being taken.
module height_to_normal_pixel (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_valid,
    output logic                                   o_ready,
    input  logic signed [htn_pkg::H_W-1:0]         i_center_height,
    input  logic signed [htn_pkg::H_W-1:0]         i_up_height,
    input  logic signed [htn_pkg::H_W-1:0]         i_down_height,
    input  logic signed [htn_pkg::H_W-1:0]         i_left_height,
    input  logic signed [htn_pkg::H_W-1:0]         i_right_height,
    input  logic                                   i_has_up,
    input  logic                                   i_has_down,
    input  logic                                   i_has_left,
    input  logic                                   i_has_right,
    output logic                                   o_valid,
    input  logic                                   i_ready,
    output logic [htn_pkg::OUT_BITS-1:0]           o_normal_x,
    output logic [htn_pkg::OUT_BITS-1:0]           o_normal_y,
    output logic [htn_pkg::OUT_BITS-1:0]           o_normal_z,
    output logic                                   o_was_clamped
);
    import htn_pkg::*;

    logic                    en;
    logic [LAT-1:0]          r_vld;

    // entry stages
    logic signed [D_W-1:0]   r_dif  [N_TRI];
    logic [N_TRI-1:0]        r_tri;
    logic [2*D_W-1:0]        r_dsq  [N_TRI];
    logic signed [D_W-1:0]   r_dif2 [N_TRI];
    logic [N_TRI-1:0]        r_tri2;

    // per-triangle root
    t_sq_st                  r_s1   [S1_STEPS+1][N_TRI];
    t_sq_st                  n_s1   [S1_STEPS][N_TRI];
    logic signed [D_W-1:0]   r_s1d  [S1_STEPS+1][N_TRI];
    logic [N_TRI-1:0]        r_s1e  [S1_STEPS+1];

    // per-triangle dividers
    t_dv_st                  r_d1   [DIV_STEPS+1][N_LANE];
    t_dv_st                  n_d1   [DIV_STEPS][N_LANE];
    logic [D_W-1:0]          r_d1den[DIV_STEPS+1][N_TRI];
    logic [N_LANE-1:0]       r_d1neg[DIV_STEPS+1];
    logic [N_TRI-1:0]        r_d1e  [DIV_STEPS+1];

    // sum vector
    logic signed [SUM_W-1:0] n_sv [3];
    logic signed [SUM_W-1:0] r_sv [3];
    logic [SQ_W-1:0]         r_p  [3];
    logic signed [SUM_W-1:0] r_c2 [3];

    // normalisation root and dividers
    t_sq_st                  r_s2   [S2_STEPS+1];
    t_sq_st                  n_s2   [S2_STEPS];
    logic signed [SUM_W-1:0] r_s2c  [S2_STEPS+1][3];
    t_dv_st                  r_d2   [DIV_STEPS+1][3];
    t_dv_st                  n_d2   [DIV_STEPS][3];
    logic [L2_W-1:0]         r_d2den[DIV_STEPS+1];
    logic [2:0]              r_d2neg[DIV_STEPS+1];
    logic                    r_d2z  [DIV_STEPS+1];

    // mapping and output
    logic [T_W-1:0]          n_t [3];
    logic [2:0]              n_cl;
    logic [T_W-1:0]          r_t [3];
    logic                    r_cl;
    logic [M_W-1:0]          r_m [3];
    logic                    r_cl2;
    logic [M_W:0]            n_rnd [3];
    logic [OUT_BITS-1:0]     r_out [3];
    logic                    r_clo;

    assign en      = ~r_vld[LAT-1] | i_ready;
    assign o_ready = en;
    assign o_valid = r_vld[LAT-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[LAT-2:0], i_valid};
        end
    end

    always_comb begin
        for (int j = 0; j < S1_STEPS; j++) begin
            for (int k = 0; k < N_TRI; k++) begin
                n_s1[j][k] = sqrt_step(r_s1[j][k], SQ_W'(1) << (2 * (S1_STEPS - 1 - j)));
            end
        end
        for (int j = 0; j < DIV_STEPS; j++) begin
            for (int k = 0; k < N_TRI; k++) begin
                for (int m = 0; m < 3; m++) begin
                    n_d1[j][3*k+m] = div_step(r_d1[j][3*k+m],
                        SQ_W'(r_d1den[j][k]) << (DIV_STEPS - 1 - j));
                end
            end
        end
        for (int j = 0; j < S2_STEPS; j++) begin
            n_s2[j] = sqrt_step(r_s2[j], SQ_W'(1) << (2 * (S2_STEPS - 1 - j)));
        end
        for (int j = 0; j < DIV_STEPS; j++) begin
            for (int c = 0; c < 3; c++) begin
                n_d2[j][c] = div_step(r_d2[j][c],
                    SQ_W'(r_d2den[j]) << (DIV_STEPS - 1 - j));
            end
        end
    end

    // signed sum of the triangle terms
    always_comb begin
        n_sv[0] = sterm(r_d1[DIV_STEPS][3*0+LN_B].q, r_d1neg[DIV_STEPS][3*0+LN_B],
                        r_d1e[DIV_STEPS][0])
                + sterm(r_d1[DIV_STEPS][3*1+LN_A].q, r_d1neg[DIV_STEPS][3*1+LN_A],
                        r_d1e[DIV_STEPS][1])
                - sterm(r_d1[DIV_STEPS][3*2+LN_B].q, r_d1neg[DIV_STEPS][3*2+LN_B],
                        r_d1e[DIV_STEPS][2])
                - sterm(r_d1[DIV_STEPS][3*3+LN_A].q, r_d1neg[DIV_STEPS][3*3+LN_A],
                        r_d1e[DIV_STEPS][3]);
        n_sv[1] = sterm(r_d1[DIV_STEPS][3*1+LN_B].q, r_d1neg[DIV_STEPS][3*1+LN_B],
                        r_d1e[DIV_STEPS][1])
                + sterm(r_d1[DIV_STEPS][3*2+LN_A].q, r_d1neg[DIV_STEPS][3*2+LN_A],
                        r_d1e[DIV_STEPS][2])
                - sterm(r_d1[DIV_STEPS][3*0+LN_A].q, r_d1neg[DIV_STEPS][3*0+LN_A],
                        r_d1e[DIV_STEPS][0])
                - sterm(r_d1[DIV_STEPS][3*3+LN_B].q, r_d1neg[DIV_STEPS][3*3+LN_B],
                        r_d1e[DIV_STEPS][3]);
        n_sv[2] = '0;
        for (int k = 0; k < N_TRI; k++) begin
            n_sv[2] = n_sv[2] + sterm(r_d1[DIV_STEPS][3*k+LN_Z].q, 1'b0,
                                      r_d1e[DIV_STEPS][k]);
        end
    end

    // map n to n+1, clamped to 0..2.0; a zero-length sum reads as (0,0,1)
    always_comb begin
        logic signed [SUM_W-1:0] nv;
        logic signed [SUM_W-1:0] tv;
        for (int c = 0; c < 3; c++) begin
            if (r_d2z[DIV_STEPS]) begin
                nv = (c == 2) ? (SUM_W'(1) <<< NRM_FRAC) : '0;
            end else begin
                nv = SUM_W'(r_d2[DIV_STEPS][c].q);
                if (r_d2neg[DIV_STEPS][c]) begin
                    nv = -nv;
                end
            end
            tv = nv + (SUM_W'(1) <<< NRM_FRAC);
            n_cl[c] = 1'b0;
            if (tv < 0) begin
                tv      = '0;
                n_cl[c] = 1'b1;
            end else if (tv > (SUM_W'(1) <<< (NRM_FRAC + 1))) begin
                tv      = SUM_W'(1) <<< (NRM_FRAC + 1);
                n_cl[c] = 1'b1;
            end
            n_t[c] = T_W'(tv);
        end
    end

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            n_rnd[c] = (M_W+1)'(r_m[c]) + ((M_W+1)'(1) << NRM_FRAC);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            // differences to the centre
            r_dif[DIR_UP]    <= D_W'(i_up_height)    - D_W'(i_center_height);
            r_dif[DIR_DOWN]  <= D_W'(i_down_height)  - D_W'(i_center_height);
            r_dif[DIR_LEFT]  <= D_W'(i_left_height)  - D_W'(i_center_height);
            r_dif[DIR_RIGHT] <= D_W'(i_right_height) - D_W'(i_center_height);
            r_tri <= {i_has_up & i_has_right, i_has_down & i_has_right,
                      i_has_down & i_has_left, i_has_up & i_has_left};

            for (int i = 0; i < N_TRI; i++) begin
                r_dsq[i]  <= (2*D_W)'(r_dif[i] * r_dif[i]);
                r_dif2[i] <= r_dif[i];
            end
            r_tri2 <= r_tri;

            // root of a^2 + b^2 + 1 per triangle
            for (int k = 0; k < N_TRI; k++) begin
                r_s1[0][k].v <= SQ_W'(r_dsq[TRI_A[k]]) + SQ_W'(r_dsq[TRI_B[k]])
                              + (SQ_W'(1) << (2 * HF));
                r_s1[0][k].r <= '0;
                r_s1d[0][k]  <= r_dif2[k];
            end
            r_s1e[0] <= r_tri2;
            for (int j = 0; j < S1_STEPS; j++) begin
                for (int k = 0; k < N_TRI; k++) begin
                    r_s1[j+1][k]  <= n_s1[j][k];
                    r_s1d[j+1][k] <= r_s1d[j][k];
                end
                r_s1e[j+1] <= r_s1e[j];
            end

            // a/len, b/len, 1/len
            for (int k = 0; k < N_TRI; k++) begin
                r_d1[0][3*k+LN_A].rem <= SQ_W'(mag_d(r_s1d[S1_STEPS][TRI_A[k]])) << NRM_FRAC;
                r_d1[0][3*k+LN_B].rem <= SQ_W'(mag_d(r_s1d[S1_STEPS][TRI_B[k]])) << NRM_FRAC;
                r_d1[0][3*k+LN_Z].rem <= SQ_W'(1) << (HF + NRM_FRAC);
                r_d1[0][3*k+LN_A].q   <= '0;
                r_d1[0][3*k+LN_B].q   <= '0;
                r_d1[0][3*k+LN_Z].q   <= '0;
                r_d1neg[0][3*k+LN_A]  <= r_s1d[S1_STEPS][TRI_A[k]][D_W-1];
                r_d1neg[0][3*k+LN_B]  <= r_s1d[S1_STEPS][TRI_B[k]][D_W-1];
                r_d1neg[0][3*k+LN_Z]  <= 1'b0;
                r_d1den[0][k]         <= D_W'(r_s1[S1_STEPS][k].r);
            end
            r_d1e[0] <= r_s1e[S1_STEPS];
            for (int j = 0; j < DIV_STEPS; j++) begin
                for (int l = 0; l < N_LANE; l++) begin
                    r_d1[j+1][l] <= n_d1[j][l];
                end
                for (int k = 0; k < N_TRI; k++) begin
                    r_d1den[j+1][k] <= r_d1den[j][k];
                end
                r_d1neg[j+1] <= r_d1neg[j];
                r_d1e[j+1]   <= r_d1e[j];
            end

            for (int c = 0; c < 3; c++) begin
                r_sv[c] <= n_sv[c];
                r_p[c]  <= SQ_W'(r_sv[c] * r_sv[c]);
                r_c2[c] <= r_sv[c];
            end

            // length of the sum vector
            r_s2[0].v <= r_p[0] + r_p[1] + r_p[2];
            r_s2[0].r <= '0;
            for (int c = 0; c < 3; c++) begin
                r_s2c[0][c] <= r_c2[c];
            end
            for (int j = 0; j < S2_STEPS; j++) begin
                r_s2[j+1] <= n_s2[j];
                for (int c = 0; c < 3; c++) begin
                    r_s2c[j+1][c] <= r_s2c[j][c];
                end
            end

            // normalise
            for (int c = 0; c < 3; c++) begin
                r_d2[0][c].rem <= SQ_W'(mag_s(r_s2c[S2_STEPS][c])) << NRM_FRAC;
                r_d2[0][c].q   <= '0;
                r_d2neg[0][c]  <= r_s2c[S2_STEPS][c][SUM_W-1];
            end
            r_d2den[0] <= L2_W'(r_s2[S2_STEPS].r);
            r_d2z[0]   <= (r_s2[S2_STEPS].r == '0);
            for (int j = 0; j < DIV_STEPS; j++) begin
                for (int c = 0; c < 3; c++) begin
                    r_d2[j+1][c] <= n_d2[j][c];
                end
                r_d2den[j+1] <= r_d2den[j];
                r_d2neg[j+1] <= r_d2neg[j];
                r_d2z[j+1]   <= r_d2z[j];
            end

            for (int c = 0; c < 3; c++) begin
                r_t[c]   <= n_t[c];
                r_m[c]   <= M_W'(r_t[c]) * M_W'((1 << OUT_BITS) - 1);
                r_out[c] <= n_rnd[c][NRM_FRAC+1 +: OUT_BITS];
            end
            r_cl  <= |n_cl;
            r_cl2 <= r_cl;
            r_clo <= r_cl2;
        end
    end

    assign o_normal_x    = r_out[0];
    assign o_normal_y    = r_out[1];
    assign o_normal_z    = r_out[2];
    assign o_was_clamped = r_clo;

    // a component never exceeds the sum length, so the clamp cannot fire
    a_no_clamp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !o_was_clamped)
        else $error("clamp flag set on a normalised result");

    // every triangle adds a positive z term, so z maps to at least one half
    a_z_upper: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_normal_z[OUT_BITS-1])
        else $error("z component below one half");

    // triangle length is at least one
    a_len_min: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[2+S1_STEPS] |->
            (r_s1[S1_STEPS][0].r >= (SQ_W'(1) << HF)) &&
            (r_s1[S1_STEPS][1].r >= (SQ_W'(1) << HF)) &&
            (r_s1[S1_STEPS][2].r >= (SQ_W'(1) << HF)) &&
            (r_s1[S1_STEPS][3].r >= (SQ_W'(1) << HF)))
        else $error("triangle length below one");

    // a stalled pipeline keeps its occupancy
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !en |=> $stable(r_vld))
        else $error("pipeline moved while stalled");

endmodule

// ===== verif/tb.sv =====
// self-checking testbench for the height-to-normal pixel pipeline
module tb;
    import htn_pkg::*;

    typedef struct {
        logic [OUT_BITS-1:0] nx;
        logic [OUT_BITS-1:0] ny;
        logic [OUT_BITS-1:0] nz;
        logic                clamped;
    } t_normal;

    logic                    i_clk;
    logic                    i_rst_n;
    logic                    i_valid;
    logic                    o_ready;
    logic signed [H_W-1:0]   i_center_height;
    logic signed [H_W-1:0]   i_up_height;
    logic signed [H_W-1:0]   i_down_height;
    logic signed [H_W-1:0]   i_left_height;
    logic signed [H_W-1:0]   i_right_height;
    logic                    i_has_up;
    logic                    i_has_down;
    logic                    i_has_left;
    logic                    i_has_right;
    logic                    o_valid;
    logic                    i_ready;
    logic [OUT_BITS-1:0]     o_normal_x;
    logic [OUT_BITS-1:0]     o_normal_y;
    logic [OUT_BITS-1:0]     o_normal_z;
    logic                    o_was_clamped;

    t_normal expected_normals[$];
    int      n_errors;
    int      n_pixels;
    int      n_normals;
    int      send_idle_pct;
    int      recv_stall_pct;
    int      hold_off_cycles;

    height_to_normal_pixel uut (.*);

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #50000000;
        $display("timeout at %0t", $time);
        $display("Simulation FAILED");
        $finish;
    end

    function automatic longint unsigned int_sqrt(longint unsigned v);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b >>= 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    // signed quotient in Q.24, truncated toward zero
    function automatic longint unit_div(longint num, longint unsigned den);
        longint unsigned mag;
        longint unsigned q;
        if (den == 0) return 0;
        mag = (num < 0) ? longint'(-num) : num;
        q = (mag << NRM_FRAC) / den;
        return (num < 0) ? -longint'(q) : longint'(q);
    endfunction

    function automatic logic [OUT_BITS-1:0] map_component(longint n, ref logic clamped);
        longint          t;
        longint unsigned maxv;
        t = n + (64'sd1 <<< NRM_FRAC);
        maxv = (64'd1 << OUT_BITS) - 1;
        if (t < 0) begin
            t = 0;
            clamped = 1'b1;
        end else if (t > (64'sd1 <<< (NRM_FRAC + 1))) begin
            t = 64'sd1 <<< (NRM_FRAC + 1);
            clamped = 1'b1;
        end
        return OUT_BITS'((longint'(t) * maxv + (64'd1 << NRM_FRAC)) >> (NRM_FRAC + 1));
    endfunction

    function automatic t_normal pixel_normal(
        logic signed [H_W-1:0] c, logic signed [H_W-1:0] u, logic signed [H_W-1:0] d,
        logic signed [H_W-1:0] l, logic signed [H_W-1:0] r,
        logic hu, logic hd, logic hl, logic hr);
        longint          dif[4];
        longint          sv[3];
        longint          a;
        longint          b;
        longint          ta;
        longint          tb;
        longint          tz;
        longint          n[3];
        longint unsigned len;
        t_normal         res;
        logic            tri_on[4];
        int              k;
        dif[DIR_UP] = longint'(u) - longint'(c);
        dif[DIR_DOWN] = longint'(d) - longint'(c);
        dif[DIR_LEFT] = longint'(l) - longint'(c);
        dif[DIR_RIGHT] = longint'(r) - longint'(c);
        tri_on[0] = hu & hl;
        tri_on[1] = hd & hl;
        tri_on[2] = hd & hr;
        tri_on[3] = hu & hr;
        sv[0] = 0;
        sv[1] = 0;
        sv[2] = 0;
        for (k = 0; k < N_TRI; k++) begin
            if (tri_on[k]) begin
                a = dif[TRI_A[k]];
                b = dif[TRI_B[k]];
                len = int_sqrt(a * a + b * b + (64'd1 << (2 * HF)));
                ta = unit_div(a, len);
                tb = unit_div(b, len);
                tz = unit_div(64'sd1 <<< HF, len);
                sv[2] += tz;
                case (k)
                    0: begin sv[0] += tb; sv[1] -= ta; end
                    1: begin sv[0] += ta; sv[1] += tb; end
                    2: begin sv[0] -= tb; sv[1] += ta; end
                    default: begin sv[0] -= ta; sv[1] -= tb; end
                endcase
            end
        end
        len = int_sqrt(sv[0] * sv[0] + sv[1] * sv[1] + sv[2] * sv[2]);
        n[0] = 0;
        n[1] = 0;
        n[2] = 64'sd1 <<< NRM_FRAC;
        if (len != 0) begin
            for (k = 0; k < 3; k++) n[k] = unit_div(sv[k], len);
        end
        res.clamped = 1'b0;
        res.nx = map_component(n[0], res.clamped);
        res.ny = map_component(n[1], res.clamped);
        res.nz = map_component(n[2], res.clamped);
        return res;
    endfunction

    // valid stays high between back-to-back transfers and drops only while idle
    task automatic send_pixel(
        logic signed [H_W-1:0] c, logic signed [H_W-1:0] u, logic signed [H_W-1:0] d,
        logic signed [H_W-1:0] l, logic signed [H_W-1:0] r, logic [3:0] flags);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_center_height <= c;
        i_up_height <= u;
        i_down_height <= d;
        i_left_height <= l;
        i_right_height <= r;
        {i_has_up, i_has_down, i_has_left, i_has_right} <= flags;
        expected_normals.push_back(pixel_normal(c, u, d, l, r,
            flags[3], flags[2], flags[1], flags[0]));
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        n_pixels++;
    endtask

    // receiver stall pattern, with an optional long hold-off
    always @(posedge i_clk) begin
        if (hold_off_cycles > 0) begin
            hold_off_cycles <= hold_off_cycles - 1;
            i_ready <= 1'b0;
        end else begin
            i_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        t_normal e;
        if (i_rst_n && o_valid && i_ready) begin
            n_normals++;
            if (expected_normals.size() == 0) begin
                $display("%0t: unexpected normal x=%0d y=%0d z=%0d c=%0b", $time,
                         o_normal_x, o_normal_y, o_normal_z, o_was_clamped);
                n_errors++;
            end else begin
                e = expected_normals.pop_front();
                if (o_normal_x !== e.nx) begin
                    $display("%0t: normal_x expected %0d got %0d", $time, e.nx, o_normal_x);
                    n_errors++;
                end
                if (o_normal_y !== e.ny) begin
                    $display("%0t: normal_y expected %0d got %0d", $time, e.ny, o_normal_y);
                    n_errors++;
                end
                if (o_normal_z !== e.nz) begin
                    $display("%0t: normal_z expected %0d got %0d", $time, e.nz, o_normal_z);
                    n_errors++;
                end
                if (o_was_clamped !== e.clamped) begin
                    $display("%0t: was_clamped expected %0b got %0b", $time,
                             e.clamped, o_was_clamped);
                    n_errors++;
                end
            end
        end
    end

    task automatic wait_drained();
        i_valid <= 1'b0;
        while (expected_normals.size() != 0) @(posedge i_clk);
    endtask

    function automatic logic signed [H_W-1:0] rand_height(int spread);
        // mostly gentle slopes, sometimes full range
        if (spread == 0) return H_W'($urandom);
        return H_W'($signed($urandom_range(2 * spread)) - spread);
    endfunction

    task automatic random_pixel();
        logic signed [H_W-1:0] c;
        int                    spread;
        case ($urandom_range(3))
            0: spread = 0;
            1: spread = 1 << 8;
            2: spread = 1 << 13;
            default: spread = 1 << 17;
        endcase
        c = H_W'($urandom);
        if (spread == 0) begin
            send_pixel(c, rand_height(0), rand_height(0), rand_height(0), rand_height(0),
                       4'($urandom));
        end else begin
            send_pixel(c, c + rand_height(spread), c + rand_height(spread),
                       c + rand_height(spread), c + rand_height(spread),
                       ($urandom_range(3) == 0) ? 4'($urandom) : 4'hf);
        end
    endtask

    task automatic test_directed();
        logic signed [H_W-1:0] mx;
        logic signed [H_W-1:0] mn;
        int                    f;
        mx = {1'b0, {(H_W-1){1'b1}}};
        mn = {1'b1, {(H_W-1){1'b0}}};
        // every neighbour combination, including the no-triangle ones
        for (f = 0; f < 16; f++) send_pixel(0, 4096, -4096, 2048, -8192, 4'(f));
        send_pixel(0, 0, 0, 0, 0, 4'hf);
        send_pixel(mn, mx, mx, mx, mx, 4'hf);
        send_pixel(mx, mn, mn, mn, mn, 4'hf);
        send_pixel(mx, mn, mx, mn, mx, 4'hf);
        send_pixel(mn, mx, mn, mx, mn, 4'hf);
        send_pixel(mx, mx, mx, mx, mx, 4'hf);
        // equal neighbours whose slopes cancel in x and y, then a small uneven slope
        send_pixel(0, 1000, 1000, 1000, 1000, 4'hf);
        send_pixel(-1, 1, -1, 1, -1, 4'hf);
        wait_drained();
    endtask

    task automatic test_random_phase(int count, int idle, int stall);
        int k;
        send_idle_pct = idle;
        recv_stall_pct = stall;
        for (k = 0; k < count; k++) random_pixel();
    endtask

    task automatic test_backpressure();
        int k;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_off_cycles = 3 * LAT;
        for (k = 0; k < 2 * LAT; k++) random_pixel();
        wait_drained();
        // one pixel through an empty pipeline at a time
        for (k = 0; k < 5; k++) begin
            random_pixel();
            wait_drained();
        end
    endtask

    initial begin
        n_errors = 0;
        n_pixels = 0;
        n_normals = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_off_cycles = 0;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_ready = 1'b0;
        i_center_height = '0;
        i_up_height = '0;
        i_down_height = '0;
        i_left_height = '0;
        i_right_height = '0;
        {i_has_up, i_has_down, i_has_left, i_has_right} = 4'h0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_random_phase(100, 0, 0);
        test_random_phase(100, 74, 0);
        test_random_phase(100, 0, 74);
        test_random_phase(100, 6, 6);
        test_backpressure();
        test_random_phase(100, 0, 0);
        send_idle_pct = 0;
        recv_stall_pct = 0;
        wait_drained();
        repeat (LAT + 20) @(posedge i_clk);
        $display("covered %0d pixels and %0d normals: all edge-flag combinations,",
                 n_pixels, n_normals);
        $display("height extremes, random slopes, idle and stall phases, full back-pressure");
        if (n_errors == 0 && expected_normals.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
